// File: src/vliw_slot_instruction_decoder_unit_defines.svh
// Assertion macros for the slot decoder. Users provide clk and rst.
`ifndef VLIW_SLOT_INSTRUCTION_DECODER_UNIT_DEFINES_SVH
`define VLIW_SLOT_INSTRUCTION_DECODER_UNIT_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define VSD_ASSERT_IMPL(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);
// Implication checked in the cycle after the antecedent.
`define VSD_ASSERT_NEXT(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);
`endif

// File: src/vsd_pkg.sv
// ----------------------------------------------------------------------------
// vsd_pkg
// Operation codes and result record of the slot decoder.
// ----------------------------------------------------------------------------
package vsd_pkg;

  localparam logic [6:0] OP_CALL   = 7'd10;
  localparam logic [6:0] OP_CMP    = 7'd14;
  localparam logic [6:0] OP_FCMP   = 7'd15;
  localparam logic [6:0] OP_DCMP   = 7'd16;
  localparam logic [6:0] OP_RET    = 7'd17;
  localparam logic [6:0] OP_CMPI   = 7'd18;
  localparam logic [6:0] OP_FCMPI  = 7'd19;
  localparam logic [6:0] OP_DCMPI  = 7'd20;
  localparam logic [6:0] OP_STM    = 7'd21;
  localparam logic [6:0] OP_STMX   = 7'd23;
  localparam logic [6:0] OP_OUT    = 7'd25;
  localparam logic [6:0] OP_OUTI   = 7'd27;
  localparam logic [6:0] OP_STCV   = 7'd28;
  localparam logic [6:0] OP_STMV   = 7'd30;
  localparam logic [6:0] OP_STC    = 7'd32;
  localparam logic [6:0] OP_STCF   = 7'd34;
  localparam logic [6:0] OP_STMF   = 7'd36;
  localparam logic [6:0] OP_STCD   = 7'd38;
  localparam logic [6:0] OP_STMD   = 7'd40;
  localparam logic [6:0] OP_RRR    = 7'd42;
  localparam logic [6:0] OP_RRI    = 7'd55;
  localparam logic [6:0] OP_RI     = 7'd68;
  localparam logic [6:0] OP_XCHG   = 7'd81;
  localparam logic [6:0] OP_NOP    = 7'd82;
  localparam logic [6:0] OP_MOVEI  = 7'd83;
  localparam logic [6:0] OP_STDMA  = 7'd84;
  localparam logic [6:0] OP_STDMAR = 7'd86;
  localparam logic [6:0] OP_DMAIR  = 7'd88;
  localparam logic [6:0] OP_WAIT   = 7'd89;
  localparam logic [6:0] OP_VEC    = 7'd90;

  localparam logic [1:0] UNIT_BR  = 2'd0;
  localparam logic [1:0] UNIT_LSU = 2'd1;
  localparam logic [1:0] UNIT_ALU = 2'd2;
  localparam logic [1:0] UNIT_VEC = 2'd3;

  localparam logic [6:0] REG_X_BASE  = 7'd62;
  localparam logic [6:0] REG_V_BASE  = 7'd56;
  localparam logic [6:0] REG_F_BASE  = 7'd60;
  localparam logic [6:0] REG_D_BASE  = 7'd58;

  typedef struct packed {
    logic        legal;
    logic [6:0]  operation;
    logic [11:0] width_code;
    logic [31:0] operand_a;
    logic [6:0]  operand_b;
    logic [7:0]  operand_c;
    logic [23:0] extra_data;
  } dec_t;

endpackage

// File: src/vliw_slot_instruction_decoder_unit.sv
// ----------------------------------------------------------------------------
// vliw_slot_instruction_decoder_unit
// Decodes one instruction word per transaction according to its bundle slot.
// ----------------------------------------------------------------------------
// channel  direction  handshake           payload
// in       input      in_valid/in_stall   slot, pc, instr_word
// out      output     out_valid/out_stall legal .. extra_data
//
// From input transaction to result: input register, decode, result register.
// One transaction per cycle sustained while the result is not stalled.
// Reset empties both registers. A stalled result holds; the input register
// refills in the same cycle the result register moves.
module vliw_slot_instruction_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  slot,
  input  logic [31:0] pc,
  input  logic [31:0] instr_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        legal,
  output logic [6:0]  operation,
  output logic [11:0] width_code,
  output logic [31:0] operand_a,
  output logic [6:0]  operand_b,
  output logic [7:0]  operand_c,
  output logic [23:0] extra_data
);

`include "vliw_slot_instruction_decoder_unit_defines.svh"

  logic          s1_valid;
  logic [1:0]    s1_slot;
  logic [31:0]   s1_pc;
  logic [31:0]   s1_word;
  vsd_pkg::dec_t dec;
  vsd_pkg::dec_t res;
  logic          s2_move;

  assign s2_move  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !s2_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      s1_slot <= slot;
      s1_pc   <= pc;
      s1_word <= instr_word;
    end
  end

  vsd_decode u_dec (
    .slot (s1_slot),
    .pc   (s1_pc),
    .w    (s1_word),
    .d    (dec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_move) begin
      out_valid <= s1_valid;
    end
    if (s2_move && s1_valid) begin
      res <= dec;
    end
  end

  assign legal      = res.legal;
  assign operation  = res.operation;
  assign width_code = res.width_code;
  assign operand_a  = res.operand_a;
  assign operand_b  = res.operand_b;
  assign operand_c  = res.operand_c;
  assign extra_data = res.extra_data;

  `VSD_ASSERT_IMPL(a_illegal_zero, out_valid && !legal, res == '0, "illegal result not cleared")
  `VSD_ASSERT_NEXT(a_stall_hold, out_valid && out_stall, out_valid && $stable(res), "stall hold")
  `VSD_ASSERT_NEXT(a_s1_flow, s1_valid && s2_move, out_valid, "decoded transaction lost")

endmodule

// File: src/vsd_decode.sv
// ----------------------------------------------------------------------------
// vsd_decode
// Combinational decode of one instruction word for its bundle slot.
// ----------------------------------------------------------------------------
module vsd_decode (
  input  logic [1:0]     slot,
  input  logic [31:0]    pc,
  input  logic [31:0]    w,
  output vsd_pkg::dec_t  d
);

  logic [31:0] rel;
  vsd_pkg::dec_t r;

  // pc + 2 * sext14(label)
  assign rel = pc + {{17{w[25]}}, w[25:12], 1'b0};

  always_comb begin
    r = '0;
    r.legal = 1'b1;
    if (slot[1] && w[1:0] != vsd_pkg::UNIT_ALU) begin
      r.legal = 1'b0;
    end else begin
      unique case (w[1:0])
        vsd_pkg::UNIT_BR: begin
          if (!slot[0]) begin
            unique case (w[3:2])
              2'd0: begin
                unique case (w[5:4])
                  2'd0: begin
                    r.operation = vsd_pkg::OP_CMP;
                    r.width_code = {10'd0, w[9:8]};
                    r.operand_a = {26'd0, w[25:20]};
                    r.operand_b = {1'b0, w[31:26]};
                  end
                  2'd1: begin
                    r.operation = vsd_pkg::OP_FCMP;
                    r.operand_a = {25'd0, w[24:18]};
                    r.operand_b = w[31:25];
                  end
                  2'd2: begin
                    r.operation = vsd_pkg::OP_DCMP;
                    r.operand_a = {26'd0, w[25:20]};
                    r.operand_b = {1'b0, w[31:26]};
                  end
                  default: begin
                    unique case (w[7:6])
                      2'd0: begin
                        if (w[11:8] > 4'd9) begin
                          r.legal = 1'b0;
                        end else begin
                          r.operation = {3'd0, w[11:8]};
                          r.operand_a = rel;
                        end
                      end
                      2'd1: r.legal = 1'b0;
                      2'd2: begin
                        r.operation = vsd_pkg::OP_CALL + {5'd0, w[9:8]};
                        r.operand_a = w[9] ? rel : {17'd0, w[25:12], 1'b0};
                      end
                      default: r.operation = vsd_pkg::OP_RET;
                    endcase
                  end
                endcase
              end
              2'd1: begin
                r.operation = vsd_pkg::OP_CMPI;
                r.width_code = {10'd0, w[5:4]};
                r.operand_a = {12'd0, w[25:6]};
                r.operand_b = {1'b0, w[31:26]};
              end
              2'd2: begin
                r.operation = vsd_pkg::OP_FCMPI;
                r.operand_a = {11'd0, w[24:4]};
                r.operand_b = w[31:25];
              end
              default: begin
                r.operation = vsd_pkg::OP_DCMPI;
                r.operand_a = {10'd0, w[25:4]};
                r.operand_b = {1'b0, w[31:26]};
              end
            endcase
          end else if (!w[2]) begin
            r.operation = vsd_pkg::OP_STDMA + {6'd0, ~w[3]};
            r.width_code = {11'd0, w[4]};
            r.operand_a = 32'(vsd_pkg::REG_F_BASE) + {30'd0, w[6:5]};
            r.operand_b = vsd_pkg::REG_D_BASE + {6'd0, w[7]};
            r.extra_data = {w[31:20], w[19:8]};
          end else if (w[7:5] == 3'd0) begin
            r.operation = w[4] ? vsd_pkg::OP_DMAIR
                               : vsd_pkg::OP_STDMAR + {6'd0, ~w[3]};
            r.width_code = w[19:8];
            r.operand_a = {26'd0, w[13:8]};
            r.operand_b = {1'b0, w[25:20]};
          end else if (w[7:4] == 4'hF) begin
            r.operation = vsd_pkg::OP_WAIT;
          end else begin
            r.legal = 1'b0;
          end
        end
        vsd_pkg::UNIT_LSU: begin
          unique case (w[3:2])
            2'd0, 2'd2: begin
              r.extra_data = {23'd0, w[4]};
              r.operation = (w[3] ? vsd_pkg::OP_STC : vsd_pkg::OP_STM) + {6'd0, ~w[5]};
              r.width_code = {10'd0, w[7:6]};
              r.operand_a = {20'd0, w[19:8]};
              r.operand_b = {1'b0, w[25:20]};
              r.operand_c = {2'd0, w[31:26]};
            end
            2'd1: begin
              unique case (w[5:4])
                2'd0: begin
                  r.operation = vsd_pkg::OP_STMX + {6'd0, ~w[6]};
                  r.width_code = {10'd0, w[8:7]};
                  r.operand_a = {16'd0, w[24:9]};
                  r.operand_b = vsd_pkg::REG_X_BASE + {6'd0, w[25]};
                  r.operand_c = {2'd0, w[31:26]};
                end
                2'd1: begin
                  r.operation = vsd_pkg::OP_OUT + {6'd0, ~w[6]};
                  r.width_code = {10'd0, w[8:7]};
                  r.operand_a = {24'd0, w[23:16]};
                  r.operand_c = {2'd0, w[31:26]};
                end
                2'd2: begin
                  r.operation = vsd_pkg::OP_OUTI;
                  r.width_code = {11'd0, w[7]};
                  r.operand_a = {16'd0, w[31:16]};
                  r.operand_c = {2'd0, w[31:26]};
                end
                default: begin
                  r.extra_data = {23'd0, w[8]};
                  r.operation = (w[7] ? vsd_pkg::OP_STCV : vsd_pkg::OP_STMV)
                                + {6'd0, ~w[6]};
                  r.operand_a = {17'd0, w[23:9]};
                  r.operand_b = vsd_pkg::REG_V_BASE + {4'd0, w[27:25]};
                  r.operand_c = {2'd0, w[31:26]};
                end
              endcase
            end
            default: begin
              r.extra_data = {23'd0, w[7]};
              if (!w[4]) begin
                r.operation = (w[5] ? vsd_pkg::OP_STCF : vsd_pkg::OP_STMF)
                              + {6'd0, ~w[6]};
                r.operand_a = {17'd0, w[22:8]};
                r.operand_b = vsd_pkg::REG_F_BASE + {5'd0, w[24:23]};
                r.operand_c = {1'b0, w[31:25]};
              end else begin
                r.operation = (w[5] ? vsd_pkg::OP_STCD : vsd_pkg::OP_STMD)
                              + {6'd0, ~w[6]};
                r.operand_a = {16'd0, w[23:8]};
                r.operand_b = vsd_pkg::REG_F_BASE + {5'd0, w[25:24]};
                r.operand_c = {2'd0, w[31:26]};
              end
            end
          endcase
        end
        vsd_pkg::UNIT_ALU: begin
          unique case (w[3:2])
            2'd0: begin
              if (w[6:4] == 3'd0) begin
                if (w[11:8] > 4'd12) begin
                  r.legal = 1'b0;
                end else begin
                  r.operation = vsd_pkg::OP_RRR + {3'd0, w[11:8]};
                  r.width_code = {10'd0, w[13:12]};
                  r.operand_a = {26'd0, w[19:14]};
                  r.operand_b = {1'b0, w[25:20]};
                  r.operand_c = {2'd0, w[31:26]};
                end
              end else if (w[6:4] == 3'd2) begin
                r.operation = vsd_pkg::OP_XCHG;
              end else if (w[6:4] == 3'd6) begin
                r.operation = vsd_pkg::OP_NOP;
                r.extra_data = {23'd0, w[7]};
              end else begin
                r.legal = 1'b0;
              end
            end
            2'd1, 2'd2: begin
              if (w[7:4] > 4'd12) begin
                r.legal = 1'b0;
              end else begin
                r.operation = (w[2] ? vsd_pkg::OP_RRI : vsd_pkg::OP_RI) + {3'd0, w[7:4]};
                r.width_code = {10'd0, w[9:8]};
                if (w[2]) begin
                  r.operand_a = {22'd0, w[19:10]};
                  r.operand_b = {1'b0, w[25:20]};
                end else begin
                  r.operand_a = {16'd0, w[25:10]};
                end
                r.operand_c = {2'd0, w[31:26]};
              end
            end
            default: begin
              r.operation = vsd_pkg::OP_MOVEI;
              r.operand_a = {10'd0, w[25:4]};
              r.operand_c = {2'd0, w[31:26]};
            end
          endcase
        end
        default: r.operation = vsd_pkg::OP_VEC;
      endcase
    end
    d = r.legal ? r : '0;
  end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Slot decoder check: directed and random instruction words per slot, with
// random idle bursts on both channels, and each result compared against a
// local decode model.
// ----------------------------------------------------------------------------
module tb;

  class decode_scoreboard;
    vsd_pkg::dec_t pending[$];
    int            errors;

    function logic [31:0] branch_target(logic [31:0] base, logic [13:0] label);
      logic [31:0] sx;
      sx = {{18{label[13]}}, label};
      return base + (sx << 1);
    endfunction

    function vsd_pkg::dec_t decode(logic [1:0] sl, logic [31:0] base, logic [31:0] w);
      vsd_pkg::dec_t d;
      logic [3:0] sel;
      d = '0;
      d.legal = 1'b1;
      if (sl > 2'd1 && w[1:0] != vsd_pkg::UNIT_ALU) begin
        d.legal = 1'b0;
      end else if (w[1:0] == vsd_pkg::UNIT_VEC) begin
        d.operation = vsd_pkg::OP_VEC;
      end else if (w[1:0] == vsd_pkg::UNIT_BR && sl == 2'd0) begin
        unique case (w[3:2])
          2'd0: begin
            unique case (w[5:4])
              2'd0: begin
                d.operation = vsd_pkg::OP_CMP; d.width_code = 12'(w[9:8]);
                d.operand_a = 32'(w[25:20]); d.operand_b = 7'(w[31:26]);
              end
              2'd1: begin
                d.operation = vsd_pkg::OP_FCMP; d.operand_a = 32'(w[24:18]);
                d.operand_b = w[31:25];
              end
              2'd2: begin
                d.operation = vsd_pkg::OP_DCMP; d.operand_a = 32'(w[25:20]);
                d.operand_b = 7'(w[31:26]);
              end
              default: begin
                unique case (w[7:6])
                  2'd0: begin
                    if (w[11:8] > 4'd9) d.legal = 1'b0;
                    d.operation = 7'(w[11:8]);
                    d.operand_a = branch_target(base, w[25:12]);
                  end
                  2'd1: d.legal = 1'b0;
                  2'd2: begin
                    d.operation = vsd_pkg::OP_CALL + 7'(w[9:8]);
                    d.operand_a = w[9] ? branch_target(base, w[25:12])
                                       : {17'd0, w[25:12], 1'b0};
                  end
                  default: d.operation = vsd_pkg::OP_RET;
                endcase
              end
            endcase
          end
          2'd1: begin
            d.operation = vsd_pkg::OP_CMPI; d.width_code = 12'(w[5:4]);
            d.operand_a = 32'(w[25:6]); d.operand_b = 7'(w[31:26]);
          end
          2'd2: begin
            d.operation = vsd_pkg::OP_FCMPI; d.operand_a = 32'(w[24:4]);
            d.operand_b = w[31:25];
          end
          default: begin
            d.operation = vsd_pkg::OP_DCMPI; d.operand_a = 32'(w[25:4]);
            d.operand_b = 7'(w[31:26]);
          end
        endcase
      end else if (w[1:0] == vsd_pkg::UNIT_BR) begin
        // slot 1: DMA / AGU
        if (!w[2]) begin
          d.operation = vsd_pkg::OP_STDMA + 7'(!w[3]);
          d.width_code = 12'(w[4]);
          d.operand_a = 32'(w[6:5]) + 32'(vsd_pkg::REG_F_BASE);
          d.operand_b = 7'(w[7]) + vsd_pkg::REG_D_BASE;
          d.extra_data = {w[31:20], w[19:8]};
        end else if (w[7:4] == 4'd0 || w[7:4] == 4'd1) begin
          d.operation = w[7:4] == 4'd0 ? vsd_pkg::OP_STDMAR + 7'(!w[3])
                                       : vsd_pkg::OP_DMAIR;
          d.width_code = w[19:8];
          d.operand_a = 32'(w[13:8]);
          d.operand_b = 7'(w[25:20]);
        end else if (w[7:4] == 4'd15) begin
          d.operation = vsd_pkg::OP_WAIT;
        end else begin
          d.legal = 1'b0;
        end
      end else if (w[1:0] == vsd_pkg::UNIT_LSU) begin
        if (w[3:2] == 2'd0 || w[3:2] == 2'd2) begin
          d.extra_data = 24'(w[4]);
          d.operation = (w[3:2] == 2'd0 ? vsd_pkg::OP_STM : vsd_pkg::OP_STC)
                        + 7'(!w[5]);
          d.width_code = 12'(w[7:6]);
          d.operand_a = 32'(w[19:8]);
          d.operand_b = 7'(w[25:20]);
          d.operand_c = 8'(w[31:26]);
        end else if (w[3:2] == 2'd1) begin
          unique case (w[5:4])
            2'd0: begin
              d.operation = vsd_pkg::OP_STMX + 7'(!w[6]); d.width_code = 12'(w[8:7]);
              d.operand_a = 32'(w[24:9]); d.operand_b = 7'(w[25]) + vsd_pkg::REG_X_BASE;
              d.operand_c = 8'(w[31:26]);
            end
            2'd1: begin
              d.operation = vsd_pkg::OP_OUT + 7'(!w[6]); d.width_code = 12'(w[8:7]);
              d.operand_a = 32'(w[23:16]); d.operand_c = 8'(w[31:26]);
            end
            2'd2: begin
              d.operation = vsd_pkg::OP_OUTI; d.width_code = 12'(w[7]);
              d.operand_a = 32'(w[31:16]); d.operand_c = 8'(w[31:26]);
            end
            default: begin
              d.extra_data = 24'(w[8]);
              d.operation = (w[7] ? vsd_pkg::OP_STCV : vsd_pkg::OP_STMV) + 7'(!w[6]);
              d.operand_a = 32'(w[23:9]);
              d.operand_b = 7'(w[27:25]) + vsd_pkg::REG_V_BASE;
              d.operand_c = 8'(w[31:26]);
            end
          endcase
        end else begin
          d.extra_data = 24'(w[7]);
          if (!w[4]) begin
            d.operation = (w[5] ? vsd_pkg::OP_STCF : vsd_pkg::OP_STMF) + 7'(!w[6]);
            d.operand_a = 32'(w[22:8]);
            d.operand_b = 7'(w[24:23]) + vsd_pkg::REG_F_BASE;
            d.operand_c = w[31:25];
          end else begin
            d.operation = (w[5] ? vsd_pkg::OP_STCD : vsd_pkg::OP_STMD) + 7'(!w[6]);
            d.operand_a = 32'(w[23:8]);
            d.operand_b = 7'(w[25:24]) + vsd_pkg::REG_F_BASE;
            d.operand_c = 8'(w[31:26]);
          end
        end
      end else begin
        // ALU
        if (w[3:2] == 2'd0) begin
          if (w[6:4] == 3'd0) begin
            sel = w[11:8];
            if (sel > 4'd12) d.legal = 1'b0;
            d.operation = vsd_pkg::OP_RRR + 7'(sel); d.width_code = 12'(w[13:12]);
            d.operand_a = 32'(w[19:14]); d.operand_b = 7'(w[25:20]);
            d.operand_c = 8'(w[31:26]);
          end else if (w[6:4] == 3'd2) begin
            d.operation = vsd_pkg::OP_XCHG;
          end else if (w[6:4] == 3'd6) begin
            d.operation = vsd_pkg::OP_NOP; d.extra_data = 24'(w[7]);
          end else begin
            d.legal = 1'b0;
          end
        end else if (w[3:2] != 2'd3) begin
          sel = w[7:4];
          if (sel > 4'd12) d.legal = 1'b0;
          d.operation = (w[3:2] == 2'd1 ? vsd_pkg::OP_RRI : vsd_pkg::OP_RI) + 7'(sel);
          d.width_code = 12'(w[9:8]);
          if (w[3:2] == 2'd1) begin
            d.operand_a = 32'(w[19:10]); d.operand_b = 7'(w[25:20]);
          end else begin
            d.operand_a = 32'(w[25:10]);
          end
          d.operand_c = 8'(w[31:26]);
        end else begin
          d.operation = vsd_pkg::OP_MOVEI; d.operand_a = 32'(w[25:4]);
          d.operand_c = 8'(w[31:26]);
        end
      end
      if (!d.legal) d = '0;
      return d;
    endfunction

    function void note_input(logic [1:0] sl, logic [31:0] base, logic [31:0] w);
      pending.push_back(decode(sl, base, w));
    endfunction

    function void check_result(vsd_pkg::dec_t got);
      vsd_pkg::dec_t e;
      if (pending.size() == 0) begin
        $error("result with nothing pending");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.legal !== e.legal) begin
        $error("legal exp %0h got %0h", e.legal, got.legal); errors++;
      end
      if (got.operation !== e.operation) begin
        $error("operation exp %0d got %0d", e.operation, got.operation); errors++;
      end
      if (got.width_code !== e.width_code) begin
        $error("width_code exp %0h got %0h", e.width_code, got.width_code); errors++;
      end
      if (got.operand_a !== e.operand_a) begin
        $error("operand_a exp %0h got %0h", e.operand_a, got.operand_a); errors++;
      end
      if (got.operand_b !== e.operand_b) begin
        $error("operand_b exp %0h got %0h", e.operand_b, got.operand_b); errors++;
      end
      if (got.operand_c !== e.operand_c) begin
        $error("operand_c exp %0h got %0h", e.operand_c, got.operand_c); errors++;
      end
      if (got.extra_data !== e.extra_data) begin
        $error("extra_data exp %0h got %0h", e.extra_data, got.extra_data); errors++;
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        in_valid, in_stall, out_valid, out_stall;
  logic [1:0]  slot;
  logic [31:0] pc, instr_word;
  logic        legal;
  logic [6:0]  operation;
  logic [11:0] width_code;
  logic [31:0] operand_a;
  logic [6:0]  operand_b;
  logic [7:0]  operand_c;
  logic [23:0] extra_data;

  decode_scoreboard sb;
  bit  quiet;        // last part of the run: no idling
  bit  hold_done;
  int  sent;

  vliw_slot_instruction_decoder_unit dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // one transaction; a random idle burst may be inserted before it
  task automatic send_word(logic [1:0] sl, logic [31:0] base, logic [31:0] w);
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    slot       <= sl;
    pc         <= base;
    instr_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(sl, base, w);
    sent++;
  endtask

  // random word with a well-formed unit selector for the slot most of the time
  function automatic logic [31:0] rand_word(logic [1:0] sl);
    logic [31:0] w;
    w = $urandom;
    if (sl > 2'd1 && $urandom_range(0, 3) != 0) w[1:0] = vsd_pkg::UNIT_ALU;
    else if ($urandom_range(0, 9) == 0) w[1:0] = vsd_pkg::UNIT_VEC;
    else w[1:0] = 2'($urandom_range(0, 2));
    return w;
  endfunction

  // receiver: random stall bursts, one long hold-off
  initial begin
    int burst;
    out_stall = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!hold_done && sent > 300) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (40) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 5);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result('{legal, operation, width_code, operand_a, operand_b,
                        operand_c, extra_data});
  end

  initial begin
    int wait_cnt;
    logic [1:0] sl;
    sb = new();
    rst = 1'b1; in_valid = 1'b0; slot = '0; pc = '0; instr_word = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // directed: extremes, label sign, reserved entries, each slot
    send_word(2'd0, 32'h0000_1000, 32'h0000_0030);   // BNE, label 0
    send_word(2'd0, 32'h0000_1000, 32'h0200_0030);   // label 0x2000, negative
    send_word(2'd0, 32'h0000_0000, 32'h03FF_F030);   // label -1, pc wraps
    send_word(2'd0, 32'hFFFF_FFFE, 32'h01FF_F930);   // BGES, max positive
    send_word(2'd0, 32'h0, 32'h0000_0A30);           // reserved comparator
    send_word(2'd0, 32'h0, 32'h0000_0070);           // category 1
    send_word(2'd0, 32'h10, 32'h0200_02B0);          // CALLR negative
    send_word(2'd0, 32'h10, 32'h03FF_F0B0);          // CALL
    send_word(2'd0, 32'h0, 32'hFFFF_FFF0);           // RET
    send_word(2'd0, 32'h0, 32'hFFFF_FFFC);           // DCMPI all ones
    send_word(2'd1, 32'h0, 32'hFFFF_FF00);           // STDMA all ones
    send_word(2'd1, 32'h0, 32'hFFFF_FFFC);           // WAIT
    send_word(2'd1, 32'h0, 32'h0000_0024);           // reserved list type
    send_word(2'd1, 32'h0, 32'hFFFF_F01C);           // DMAIR
    send_word(2'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);   // vector
    send_word(2'd0, 32'h0, 32'h0000_0003);           // vector
    send_word(2'd2, 32'h0, 32'hFFFF_FFFE);           // MOVEI
    send_word(2'd3, 32'h0, 32'h0000_0D02);           // reserved ALU sel
    send_word(2'd3, 32'h0, 32'h0000_0062);           // NOP
    send_word(2'd2, 32'h0, 32'h0000_0022);           // XCHG
    send_word(2'd2, 32'h0, 32'h0000_0012);           // illegal ALU type
    send_word(2'd3, 32'h0, 32'hFFFF_FFFD);           // LSU in slot 3
    send_word(2'd2, 32'h0, 32'h0000_0000);           // branch in slot 2
    send_word(2'd1, 32'h0, 32'hFFFF_FFFD);           // LSU all ones
    for (int i = 0; i < 1750; i++) begin
      if (i == 1500) quiet = 1'b1;
      sl = 2'($urandom_range(0, 3));
      send_word(sl, $urandom, rand_word(sl));
    end
    in_valid <= 1'b0;
    wait_cnt = 0;
    while (sb.pending.size() != 0 && wait_cnt < 10000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (5) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $error("%0d results never arrived", sb.pending.size());
      sb.errors++;
    end
    if (sb.errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule

// File: sim.f
+incdir+src
src/vsd_pkg.sv
src/vsd_decode.sv
src/vliw_slot_instruction_decoder_unit.sv
tb/tb.sv
